>>> src/assert_macros.svh
// Assertion macros used by the checker file of the channel pool allocator.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define CPA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("channel pool allocator: assertion failed");

// Antecedent implies consequent in the same cycle.
`define CPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("channel pool allocator: assertion failed");

// Antecedent implies consequent in the following cycle.
`define CPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("channel pool allocator: assertion failed");

`endif

>>> src/cpa_pkg.sv
// Shared types and constants of the channel pool allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  localparam int CHANNELS_DEF     = 24;
  localparam int SOURCE_SLOTS_DEF = 256;

  localparam int ACT_W       = 2;
  localparam int SID_W       = 8;
  localparam int CH_W        = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ASSIGN  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  // One entry of the source map.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] chan;
  } map_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_wr;  // write one cleared map entry and advance the sweep
    logic load;    // capture a request and read its map entry
    logic exec;    // commit map/FIFO updates and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;   // sweep is at the last map entry
    logic out_stall;  // result register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> src/cpa_ctrl.sv
// Controller of the channel pool allocator: clear sweep, request load, commit.
// Depends on cpa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module cpa_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_tvalid,
  output logic          in_tready,
  input  cpa_pkg::sts_t sts,
  output cpa_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the new result
        if (!sts.out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

>>> src/cpa_dp.sv
// Datapath of the channel pool allocator: source map memory, free-channel FIFO,
// result register. Depends on cpa_pkg; driven by cpa_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module cpa_dp #(
  parameter int CHANNELS     = cpa_pkg::CHANNELS_DEF,
  parameter int SOURCE_SLOTS = cpa_pkg::SOURCE_SLOTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [cpa_pkg::ACT_W-1:0]         in_action,
  input  wire  [cpa_pkg::SID_W-1:0]         in_source_id,
  input  cpa_pkg::cmd_t                     cmd,
  output cpa_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [cpa_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CH_W   = cpa_pkg::CH_W;
  localparam int MAP_AW = $clog2(SOURCE_SLOTS);
  localparam int CMPW   = ((MAP_AW > cpa_pkg::SID_W) ? MAP_AW : cpa_pkg::SID_W) + 1;
  localparam int PW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);

  // Source map
  cpa_pkg::map_entry_t map_mem [SOURCE_SLOTS];
  cpa_pkg::map_entry_t map_q_r;
  cpa_pkg::map_entry_t map_wd;
  logic                map_we;
  logic [MAP_AW-1:0]   clr_idx_r;

  // Captured request
  logic [cpa_pkg::ACT_W-1:0] act_r;
  logic [MAP_AW-1:0]         idx_r;
  logic                      inrange_r;

  logic [CMPW-1:0]   sid_ext;
  logic              sid_inrange;

  // Free-channel FIFO
  logic [CH_W-1:0]  fifo_r [CHANNELS];
  logic [PW-1:0]    head_r, tail_r;
  logic [CNT_W-1:0] count_r;
  logic             pop, push;

  // Result
  logic            res_ok, res_wp;
  logic [CH_W-1:0] res_ch;
  logic            out_valid_r;
  logic [cpa_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign sid_ext     = CMPW'(in_source_id);
  assign sid_inrange = sid_ext < CMPW'(SOURCE_SLOTS);

  assign sts.clr_last  = clr_idx_r == MAP_AW'(SOURCE_SLOTS - 1);
  assign sts.out_stall = out_valid_r && !out_tready;

  // Decide the result and the state updates of the captured request.
  always_comb begin
    res_ok = 1'b0;
    res_ch = '0;
    res_wp = 1'b0;
    map_we = 1'b0;
    map_wd = '0;
    pop    = 1'b0;
    push   = 1'b0;
    if (inrange_r) begin
      unique case (act_r)
        cpa_pkg::ACT_ASSIGN: begin
          if (map_q_r.valid) begin
            res_ok = 1'b1;
            res_ch = map_q_r.chan;
            res_wp = 1'b1;
          end else if (count_r != '0) begin
            res_ok       = 1'b1;
            res_ch       = fifo_r[head_r];
            pop          = 1'b1;
            map_we       = 1'b1;
            map_wd.valid = 1'b1;
            map_wd.chan  = fifo_r[head_r];
          end
        end
        cpa_pkg::ACT_RELEASE: begin
          if (map_q_r.valid) begin
            res_ok = 1'b1;
            res_ch = map_q_r.chan;
            map_we = 1'b1;
            push   = count_r < CNT_W'(CHANNELS);
          end
        end
        cpa_pkg::ACT_QUERY: begin
          if (map_q_r.valid) begin
            res_ok = 1'b1;
            res_ch = map_q_r.chan;
          end
        end
        default: ;
      endcase
    end
  end

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      map_mem[clr_idx_r] <= '0;
    end else if (cmd.exec && map_we) begin
      map_mem[idx_r] <= map_wd;
    end
    if (cmd.load && sid_inrange) begin
      map_q_r <= map_mem[sid_ext[MAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr && !sts.clr_last) begin
      clr_idx_r <= clr_idx_r + MAP_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      idx_r     <= sid_ext[MAP_AW-1:0];
      inrange_r <= sid_inrange;
    end
  end

  // Free FIFO: pop at head, push at tail, both wrapping at CHANNELS.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fifo_r[i] <= CH_W'(i);
      end
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= CNT_W'(CHANNELS);
    end else if (cmd.exec) begin
      if (pop) begin
        head_r  <= (head_r == PW'(CHANNELS - 1)) ? '0 : head_r + PW'(1);
        count_r <= count_r - CNT_W'(1);
      end
      if (push) begin
        fifo_r[tail_r] <= map_q_r.chan;
        tail_r  <= (tail_r == PW'(CHANNELS - 1)) ? '0 : tail_r + PW'(1);
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= {1'b0, res_wp, res_ch, res_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> src/channel_pool_allocator.sv
// Channel pool allocator top level: cpa_ctrl sequences cpa_dp, the map and FIFO datapath.
// A request has its source map entry read into a register; the commit state then updates the
// map and FIFO and loads the result register, held while that register is full and not taken.
// A new request is taken only after the last one commits: the map write-back follows its read.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the map while in_tready
// stays low; the free FIFO restarts with channels 0..CHANNELS-1.
`timescale 1ns / 1ps
`default_nettype none

module channel_pool_allocator #(
  parameter int CHANNELS     = cpa_pkg::CHANNELS_DEF,     // 1 to 32 voice channels
  parameter int SOURCE_SLOTS = cpa_pkg::SOURCE_SLOTS_DEF  // 2 to 4096 map entries
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [cpa_pkg::IN_TDATA_W-1:0]   in_tdata,   // action[1:0], source_id[9:2], zero
  // result channel
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [cpa_pkg::OUT_TDATA_W-1:0]  out_tdata   // ok[0], channel[5:1], was_playing[6], zero
);

  cpa_pkg::cmd_t cmd;
  cpa_pkg::sts_t sts;

  // The controller accepts a request only in its idle state; the result
  // register in the datapath lets a new request in while an old result waits.
  cpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Unpack the request fields straight into the datapath capture registers.
  cpa_dp #(
    .CHANNELS     (CHANNELS),
    .SOURCE_SLOTS (SOURCE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_action    (in_tdata[cpa_pkg::ACT_W-1:0]),
    .in_source_id (in_tdata[cpa_pkg::ACT_W +: cpa_pkg::SID_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

`default_nettype wire

>>> src/cpa_checker.sv
// Port-level checker for channel_pool_allocator, attached by bind.
// Depends on assert_macros.svh and cpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpa_checker #(
  parameter int CHANNELS = cpa_pkg::CHANNELS_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [cpa_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A failed request reports channel 0.
  `CPA_ASSERT_IMPL(a_fail_chan_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[5:1] == '0)

  // Only successful requests can report was_playing.
  `CPA_ASSERT_IMPL(a_wp_needs_ok, clk, rst_n, out_tvalid && out_tdata[6], out_tdata[0])

  // Reported channels stay within the pool.
  `CPA_ASSERT_NEVER(a_chan_range, clk, rst_n, out_tvalid && (32'(out_tdata[5:1]) >= CHANNELS))

  // One request in flight: ready drops right after an accept.
  `CPA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // A stalled result stays offered.
  `CPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

endmodule

bind channel_pool_allocator cpa_checker #(.CHANNELS(CHANNELS)) u_cpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
